FILE: src/cfcp_pkg.sv
package cfcp_pkg;

  localparam int MAX_PARAMS = 16;

  localparam int CHAR_W = 16;

  // control codes
  localparam logic [CHAR_W-1:0] CODE_END   = 16'h0000;
  localparam logic [CHAR_W-1:0] CODE_START = 16'h0001;
  localparam logic [CHAR_W-1:0] CODE_SEP   = 16'h0002;

  localparam logic [CHAR_W-1:0] CH_LT    = 16'h003C;
  localparam logic [CHAR_W-1:0] CH_GT    = 16'h003E;
  localparam logic [CHAR_W-1:0] CH_QUOT  = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_LOW_Z = 16'h007A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 16'h0020;

  localparam logic [31:0] ESC_LT   = "&lt;";
  localparam logic [31:0] ESC_GT   = "&gt;";
  localparam logic [47:0] ESC_QUOT = "&quot;";

  // result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_PARAM = 2'd1;
  localparam logic [1:0] KIND_OPEN  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  typedef enum logic [1:0] {
    ST_WAIT  = 2'd0,
    ST_NAME  = 2'd1,
    ST_PARAM = 2'd2
  } parse_state_t;

  // what follows an optional "parameter opened" result
  typedef enum logic [2:0] {
    BODY_NONE = 3'd0,
    BODY_CHAR = 3'd1,
    BODY_LT   = 3'd2,
    BODY_GT   = 3'd3,
    BODY_QUOT = 3'd4,
    BODY_END  = 3'd5
  } body_t;

  typedef struct packed {
    logic              has_open;
    logic [3:0]        open_idx;
    body_t             body;
    logic [1:0]        body_kind;
    logic [CHAR_W-1:0] body_char;
    logic [3:0]        idx;
    logic [4:0]        total;
  } plan_t;

  function automatic logic [2:0] body_len(body_t b);
    case (b)
      BODY_NONE: return 3'd0;
      BODY_CHAR: return 3'd1;
      BODY_LT:   return 3'd4;
      BODY_GT:   return 3'd4;
      BODY_QUOT: return 3'd6;
      BODY_END:  return 3'd1;
      default:   return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] esc_char(body_t b, logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (b)
      BODY_LT:   ch = ESC_LT[8*(3-32'(pos[1:0])) +: 8];
      BODY_GT:   ch = ESC_GT[8*(3-32'(pos[1:0])) +: 8];
      BODY_QUOT: if (pos < 3'd6) ch = ESC_QUOT[8*(5-32'(pos)) +: 8];
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: src/cfcp_parse.sv
module cfcp_parse #(
  parameter int MaxParams = cfcp_pkg::MAX_PARAMS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [cfcp_pkg::CHAR_W-1:0]   char_code,
  input  logic                          accept,
  output cfcp_pkg::plan_t               plan,
  output logic                          has_result
);

  localparam int CntW = $clog2(MaxParams + 1);

  cfcp_pkg::parse_state_t state, state_next;
  logic [CntW-1:0]        count, count_next;

  logic            opening;
  logic [CntW-1:0] count_open;

  always_comb begin
    opening    = ((count == '0) || (char_code == cfcp_pkg::CODE_SEP)) &&
                 (count < CntW'(MaxParams));
    count_open = count + CntW'(opening);
  end

  // next state
  always_comb begin
    state_next = state;
    count_next = count;
    if (char_code == cfcp_pkg::CODE_END) begin
      state_next = cfcp_pkg::ST_WAIT;
      count_next = '0;
    end else begin
      case (state)
        cfcp_pkg::ST_NAME: begin
          if (char_code == cfcp_pkg::CODE_SEP) state_next = cfcp_pkg::ST_PARAM;
        end
        cfcp_pkg::ST_PARAM: begin
          count_next = count_open;
        end
        default: begin
          state_next = (char_code == cfcp_pkg::CODE_START) ? cfcp_pkg::ST_NAME
                                                           : cfcp_pkg::ST_WAIT;
        end
      endcase
    end
  end

  // decoded work for this beat
  always_comb begin
    plan.has_open  = 1'b0;
    plan.open_idx  = 4'(count);
    plan.body      = cfcp_pkg::BODY_NONE;
    plan.body_kind = cfcp_pkg::KIND_PARAM;
    plan.body_char = char_code;
    plan.idx       = '0;
    plan.total     = 5'(count);
    if (char_code == cfcp_pkg::CODE_END) begin
      plan.body = cfcp_pkg::BODY_END;
    end else begin
      case (state)
        cfcp_pkg::ST_NAME: begin
          if (char_code != cfcp_pkg::CODE_SEP) begin
            plan.body      = cfcp_pkg::BODY_CHAR;
            plan.body_kind = cfcp_pkg::KIND_NAME;
            if (char_code >= cfcp_pkg::CH_LOW_A && char_code <= cfcp_pkg::CH_LOW_Z)
              plan.body_char = char_code - cfcp_pkg::CASE_OFS;
          end
        end
        cfcp_pkg::ST_PARAM: begin
          plan.has_open = opening;
          plan.total    = 5'(count_open);
          plan.idx      = (count_open == '0) ? 4'd0 : 4'(count_open - CntW'(1));
          if (char_code == cfcp_pkg::CH_LT)          plan.body = cfcp_pkg::BODY_LT;
          else if (char_code == cfcp_pkg::CH_GT)     plan.body = cfcp_pkg::BODY_GT;
          else if (char_code == cfcp_pkg::CH_QUOT)   plan.body = cfcp_pkg::BODY_QUOT;
          else if (char_code != cfcp_pkg::CODE_SEP)  plan.body = cfcp_pkg::BODY_CHAR;
        end
        default: begin
          plan.body = cfcp_pkg::BODY_NONE;
        end
      endcase
    end
    has_result = plan.has_open || (plan.body != cfcp_pkg::BODY_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfcp_pkg::ST_WAIT;
      count <= '0;
    end else if (accept) begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

FILE: src/cfcp_emit.sv
module cfcp_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  cfcp_pkg::plan_t               plan_in,
  input  logic                          load,
  output logic                          free,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [1:0]                    kind,
  output logic [cfcp_pkg::CHAR_W-1:0]   char_out,
  output logic [3:0]                    param_index,
  output logic [4:0]                    param_total,
  output logic                          last
);

  cfcp_pkg::plan_t plan;
  logic            plan_valid;
  logic [2:0]      step;

  logic [2:0]                  n_res;
  logic [2:0]                  pos;
  logic                        step_last;
  logic                        advance;
  logic [1:0]                  cur_kind;
  logic [cfcp_pkg::CHAR_W-1:0] cur_char;
  logic [3:0]                  cur_idx;

  always_comb begin
    n_res     = cfcp_pkg::body_len(plan.body) + {2'b00, plan.has_open};
    step_last = (step == n_res - 3'd1);
    pos       = step - {2'b00, plan.has_open};
    advance   = plan_valid && (!result_valid || result_ready);
    free      = !plan_valid || (advance && step_last);
  end

  always_comb begin
    cur_kind = cfcp_pkg::KIND_PARAM;
    cur_char = '0;
    cur_idx  = plan.idx;
    if (plan.has_open && step == 3'd0) begin
      cur_kind = cfcp_pkg::KIND_OPEN;
      cur_idx  = plan.open_idx;
    end else begin
      case (plan.body)
        cfcp_pkg::BODY_CHAR: begin
          cur_kind = plan.body_kind;
          cur_char = plan.body_char;
        end
        cfcp_pkg::BODY_LT, cfcp_pkg::BODY_GT, cfcp_pkg::BODY_QUOT: begin
          cur_char = {8'h00, cfcp_pkg::esc_char(plan.body, pos)};
        end
        cfcp_pkg::BODY_END: begin
          cur_kind = cfcp_pkg::KIND_END;
          cur_idx  = '0;
        end
        default: begin
          cur_idx = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
      step       <= '0;
    end else if (load) begin
      plan_valid <= 1'b1;
      step       <= '0;
    end else if (advance && step_last) begin
      plan_valid <= 1'b0;
    end else if (advance) begin
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) plan <= plan_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind        <= cur_kind;
      char_out    <= cur_char;
      param_index <= cur_idx;
      param_total <= plan.total;
      last        <= step_last;
    end
  end

endmodule

FILE: src/control_frame_command_parser.sv
// Control frame command parser.
// Input channel: one 16-bit character per beat on char_code (char_valid /
// char_ready). Code 1 opens a frame, code 2 separates parameters, code 0
// ends the frame. Output channel: one result per beat (result_valid /
// result_ready) with kind, char_out, param_index, param_total and last;
// last marks the final result caused by an input character.
// Results pass the plan register, then the result register.
// Throughput: while the receiver does not stall, a character with at most
// one result is taken every cycle; one with n results (open plus escape,
// up to 7) holds the input until its last result, as the sequencer emits
// one result a cycle, unless stalled, from a single decoded-plan register.
// Drops outside a frame, frame start and name separator give no result.
// Reset: parser returns to waiting for a frame start with a zero parameter
// count; no result is pending. When the receiver stalls, the result
// register holds its beat, the sequencer stops, and char_ready drops as
// soon as the plan register cannot be freed.
module control_frame_command_parser #(
  parameter int MaxParams = cfcp_pkg::MAX_PARAMS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          char_valid,
  output logic                          char_ready,
  input  logic [cfcp_pkg::CHAR_W-1:0]   char_code,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [1:0]                    kind,
  output logic [cfcp_pkg::CHAR_W-1:0]   char_out,
  output logic [3:0]                    param_index,
  output logic [4:0]                    param_total,
  output logic                          last
);

  cfcp_pkg::plan_t plan;
  logic            has_result;
  logic            accept;
  logic            free;

  assign char_ready = free;
  assign accept     = char_valid && free;

  cfcp_parse #(
    .MaxParams (MaxParams)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .char_code  (char_code),
    .accept     (accept),
    .plan       (plan),
    .has_result (has_result)
  );

  cfcp_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .plan_in      (plan),
    .load         (accept && has_result),
    .free         (free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .char_out     (char_out),
    .param_index  (param_index),
    .param_total  (param_total),
    .last         (last)
  );

endmodule
